### hw/rtl/ksel_pkg.sv
// Package with shared widths, types and state codes for the k-smallest selector.
`default_nettype none

package ksel_pkg;

    localparam int VALUE_W  = 64;
    localparam int SEEN_W   = 7;
    localparam int SELECT_W = 7;

    localparam logic [SEEN_W-1:0]   SEEN_MAX     = '1;
    localparam logic [SELECT_W-1:0] SELECT_RESET = 7'd10;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic              insert;
        logic              shift;
        logic [SEEN_W-1:0] seen;
    } ksel_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ksel_state_t;

endpackage

`default_nettype wire

### hw/rtl/ksel_cell.sv
// One cell of the sorted insertion chain: holds one value, compares and shifts.
`default_nettype none

module ksel_cell #(
    parameter int IDX = 0
) (
    input  wire                 aclk,
    input  ksel_pkg::ksel_ctrl_t ctrl,
    input  ksel_pkg::value_t    in_value,
    input  ksel_pkg::value_t    left_value,
    input  wire                 left_take,
    input  ksel_pkg::value_t    right_value,
    output ksel_pkg::value_t    value,
    output logic                take
);
    import ksel_pkg::*;

    localparam logic [SEEN_W-1:0] IDX_C = SEEN_W'(IDX);

    value_t val_reg;
    value_t val_next;
    logic   held;

    // entries below the fill count hold data; the rest read as empty
    assign held  = IDX_C < ctrl.seen;
    assign take  = !held || (in_value < val_reg);
    assign value = val_reg;

    always_comb begin
        val_next = val_reg;
        if (ctrl.insert && take) begin
            val_next = left_take ? left_value : in_value;
        end else if (ctrl.shift) begin
            val_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

### hw/rtl/k_smallest_select_unit.sv
// Top level of the k-smallest selector: cell chain, fill count and result sequencer.
// Timing: the first result of a set appears
//   the cycle after its final item is accepted.
// Throughput: one value per cycle while a set streams in; after the final item
//   the chain drains k results (or one too-few result), one per cycle while
//   m_tready is high, and no item is accepted until the last of them is taken.
// Reset: fill count cleared, k set to 10, no result pending; cell contents undefined.
`default_nettype none

module k_smallest_select_unit #(
    parameter int MAX_K = 10
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [ksel_pkg::VALUE_W-1:0]     s_tdata,   // [63:0] value
    input  wire                              s_tlast,   // is_final
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [ksel_pkg::VALUE_W-1:0]     m_tdata,   // [63:0] selected
    output logic                             m_tlast,   // run_end
    output logic                             m_tuser,   // [0] too_few
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [ksel_pkg::SELECT_W-1:0]    cfg_data
);
    import ksel_pkg::*;

    localparam int CNT_W = $clog2(MAX_K + 1);
    localparam logic [SELECT_W-1:0] MAX_K_SEL = SELECT_W'(MAX_K);

    ksel_state_t         state_reg, state_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic                few_reg, few_next;
    logic [SELECT_W-1:0] k_reg;

    logic                s_acc, m_acc;
    logic [SEEN_W-1:0]   seen_inc;
    logic [SELECT_W-1:0] k_eff;
    logic                few_now;
    ksel_ctrl_t          ctrl;

    value_t              cell_val  [MAX_K];
    logic                cell_take [MAX_K];

    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    assign seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 1'b1;

    always_comb begin
        k_eff = k_reg;
        if (k_reg == '0) begin
            k_eff = SELECT_W'(1);
        end else if (k_reg > MAX_K_SEL) begin
            k_eff = MAX_K_SEL;
        end
    end

    assign few_now = SELECT_W'(seen_inc) < k_eff;

    assign ctrl.insert = s_acc;
    assign ctrl.shift  = m_acc;
    assign ctrl.seen   = seen_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_K; gi++) begin : g_cell
            value_t lv, rv;
            logic   lt;
            if (gi == 0) begin : g_first
                assign lv = '0;
                assign lt = 1'b0;
            end else begin : g_mid
                assign lv = cell_val[gi-1];
                assign lt = cell_take[gi-1];
            end
            if (gi == MAX_K - 1) begin : g_last
                assign rv = cell_val[gi];
            end else begin : g_inner
                assign rv = cell_val[gi+1];
            end
            ksel_cell #(.IDX(gi)) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .in_value   (value_t'(s_tdata)),
                .left_value (lv),
                .left_take  (lt),
                .right_value(rv),
                .value      (cell_val[gi]),
                .take       (cell_take[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tlast) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_acc && (left_reg == CNT_W'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EMIT: m_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign m_tdata = few_reg ? '0 : cell_val[0];
    assign m_tlast = left_reg == CNT_W'(1);
    assign m_tuser = few_reg;

    always_comb begin
        seen_next = seen_reg;
        left_next = left_reg;
        few_next  = few_reg;
        if (s_acc) begin
            if (s_tlast) begin
                seen_next = '0;
                few_next  = few_now;
                left_next = few_now ? CNT_W'(1) : CNT_W'(k_eff);
            end else begin
                seen_next = seen_inc;
            end
        end else if (m_acc) begin
            left_next = left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seen_reg  <= '0;
            left_reg  <= '0;
            few_reg   <= 1'b0;
            k_reg     <= SELECT_RESET;
        end else begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            left_reg  <= left_next;
            few_reg   <= few_next;
            if (cfg_valid && cfg_ready) begin
                k_reg <= cfg_data;
            end
        end
    end

    a_emit_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> seen_reg == '0)
        else $error("fill count not cleared while draining");

    a_few_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == '0)
        else $error("too-few result malformed");

    a_final_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after final item");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("input not reopened after last result");

endmodule

`default_nettype wire
